@@ hw/rtl/thht_pkg.sv @@
// thht_pkg: shared types, constituent speeds, cosine coefficients and the
// phase-rate helper for the tide height core. No dependencies.
package thht_pkg;

    localparam int NCONST = 5;
    localparam int AMP_W  = 16;
    localparam int TIME_W = 35;
    localparam int LEVEL_W = 19;
    localparam int SUM_W  = 36;
    localparam int COS_W  = 17;
    localparam int TERM_W = AMP_W + COS_W;
    localparam int CFG_IDX_W = 3;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_AMP_M2 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AMP_S2 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AMP_N2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AMP_K2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AMP_M4 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DATUM  = 3'd5;

    // speeds in 1e-8 degree per hour: M2, S2, N2, K2, M4
    localparam logic [63:0] SPEED_E8 [NCONST] = '{
        64'd1449205211, 64'd1500000000, 64'd1449669388, 64'd1504106864, 64'd2898410422
    };

    localparam logic [63:0] RATE_DIV = 64'd129600000000000;

    // (2pi)^(2k)/(2k)! in Q28
    localparam logic [34:0] COEF_A1 = 35'd5298703516;
    localparam logic [34:0] COEF_A2 = 35'd17432035847;
    localparam logic [34:0] COEF_A3 = 35'd22939639693;
    localparam logic [34:0] COEF_A4 = 35'd16171797777;
    localparam logic [28:0] ONE_Q28 = 29'd268435456;

    typedef struct packed {
        logic signed [SUM_W-1:0] s0;
        logic signed [SUM_W-1:0] s1;
    } sum_pair_t;

    // round-half-up of s * 2^pb / RATE_DIV by binary long division;
    // used for elaboration-time constants only
    function automatic logic [63:0] phase_rate(input logic [63:0] s, input int pb);
        logic [63:0] r;
        logic [63:0] q;
        r = s;
        q = '0;
        for (int i = 0; i < pb; i++)
        begin
            r = r << 1;
            q = q << 1;
            if (r >= RATE_DIV)
            begin
                r = r - RATE_DIV;
                q = q | 64'd1;
            end
        end
        r = r << 1;
        if (r >= RATE_DIV)
        begin
            q = q + 64'd1;
        end
        return q;
    endfunction

endpackage

@@ hw/rtl/thht_if.sv @@
// thht_if: valid/ready channels for timestamps and tide results.
// Depends on thht_pkg for field widths.
interface thht_time_if import thht_pkg::*;;
    logic valid;
    logic ready;
    logic signed [TIME_W-1:0] time_seconds;
    modport source (output valid, output time_seconds, input ready);
    modport sink (input valid, input time_seconds, output ready);
endinterface

interface thht_level_if import thht_pkg::*;;
    logic valid;
    logic ready;
    logic signed [LEVEL_W-1:0] tide_level;
    logic rising;
    modport source (output valid, output tide_level, output rising, input ready);
    modport sink (input valid, input tide_level, input rising, output ready);
endinterface

@@ hw/rtl/tide_harmonic_height_trend_core.sv @@
// tide_harmonic_height_trend_core: top level of the five-constituent tide
// predictor. Depends on thht_pkg, thht_if, thht_cell, thht_cos.
//
// Each timestamp beat (signed seconds) yields one result beat: the tide
// height at t and a flag that is high when the height at t + TREND_LEAD is
// strictly higher. The datapath is a chain of five cells, one per
// constituent (M2, S2, N2, K2, M4); each cell turns both time points into
// phases with a constant-rate multiply, runs a six-stage polynomial cosine,
// scales by its amplitude and adds into the running sums it hands to the
// next cell. One timestamp is taken every cycle while the pipe is not
// stalled. The whole pipe advances together: it moves whenever the output
// register is empty or its beat is being taken, so a stalled result only
// holds input while it waits.
// Configuration writes land directly in the amplitude and datum registers;
// indexes beyond the datum register are ignored.
module tide_harmonic_height_trend_core import thht_pkg::*;
#(
    parameter int PHASE_BITS = 32,
    parameter int TREND_LEAD = 300
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [AMP_W-1:0]       cfg_data,
    thht_time_if.sink              req,
    thht_level_if.source           rsp
);
    logic signed [AMP_W-1:0] amp_reg [NCONST];
    logic signed [AMP_W-1:0] datum_reg;

    logic                  en;
    logic [NCONST:0]       valid_w;
    logic [PHASE_BITS-1:0] t0_w [0:NCONST];
    logic [PHASE_BITS-1:0] t1_w [0:NCONST];
    sum_pair_t             sum_w [0:NCONST];
    logic signed [63:0]    t_ext;

    logic signed [20:0] r0, r1;
    logic signed [21:0] h0, h1;
    logic signed [LEVEL_W-1:0] lvl0, lvl1;
    logic                      out_valid_reg;
    logic signed [LEVEL_W-1:0] level_reg;
    logic                      rising_reg;

    // hold the whole pipe while a result waits
    assign en = !out_valid_reg || rsp.ready;
    assign req.ready = en;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            amp_reg[0] <= 16'sd4915;
            amp_reg[1] <= 16'sd1638;
            amp_reg[2] <= 16'sd819;
            amp_reg[3] <= 16'sd410;
            amp_reg[4] <= 16'sd410;
            datum_reg  <= 16'sd4096;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_AMP_M2: amp_reg[0] <= $signed(cfg_data);
                REG_AMP_S2: amp_reg[1] <= $signed(cfg_data);
                REG_AMP_N2: amp_reg[2] <= $signed(cfg_data);
                REG_AMP_K2: amp_reg[3] <= $signed(cfg_data);
                REG_AMP_M4: amp_reg[4] <= $signed(cfg_data);
                REG_DATUM:  datum_reg  <= $signed(cfg_data);
                default:    ;
            endcase
        end
    end

    // only the low PHASE_BITS of time matter for the phase product
    assign t_ext = 64'(req.time_seconds);
    assign valid_w[0] = req.valid;
    assign t0_w[0] = t_ext[PHASE_BITS-1:0];
    assign t1_w[0] = t_ext[PHASE_BITS-1:0] + PHASE_BITS'(TREND_LEAD);
    assign sum_w[0] = '0;

    for (genvar k = 0; k < NCONST; k++)
    begin : g_cell
        thht_cell #(.PHASE_BITS(PHASE_BITS), .K(k)) u_cell (
            .clk(clk), .rst_n(rst_n), .en(en),
            .in_valid(valid_w[k]), .in_t0(t0_w[k]), .in_t1(t1_w[k]),
            .in_sum(sum_w[k]), .amp(amp_reg[k]),
            .out_valid(valid_w[k+1]), .out_t0(t0_w[k+1]), .out_t1(t1_w[k+1]),
            .out_sum(sum_w[k+1])
        );
    end

    // round by 15 bits, add datum, saturate
    always_comb
    begin
        r0 = 21'((sum_w[NCONST].s0 + SUM_W'(16384)) >>> 15);
        r1 = 21'((sum_w[NCONST].s1 + SUM_W'(16384)) >>> 15);
        h0 = 22'(r0) + 22'(datum_reg);
        h1 = 22'(r1) + 22'(datum_reg);
        if (h0 > 22'sd262143)
            lvl0 = 19'sd262143;
        else if (h0 < -22'sd262144)
            lvl0 = -19'sd262144;
        else
            lvl0 = 19'(h0);
        if (h1 > 22'sd262143)
            lvl1 = 19'sd262143;
        else if (h1 < -22'sd262144)
            lvl1 = -19'sd262144;
        else
            lvl1 = 19'(h1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= valid_w[NCONST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            level_reg  <= lvl0;
            rising_reg <= (lvl1 > lvl0);
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.tide_level = level_reg;
    assign rsp.rising = rising_reg;

    a_ready_follows_output: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready == (!rsp.valid || rsp.ready))
        else $error("input ready does not follow output stall");

    a_stall_freezes_chain: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(valid_w[NCONST:1]))
        else $error("cell chain moved during a stall");

    a_datum_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we && cfg_index == REG_DATUM |=> datum_reg == $signed($past(cfg_data)))
        else $error("datum write lost");
endmodule

@@ hw/rtl/thht_cos.sv @@
// thht_cos: six-stage cosine of a 16-bit turn fraction, signed Q15 result.
// Depends on thht_pkg for coefficients.
module thht_cos import thht_pkg::*;
(
    input  logic                    clk,
    input  logic                    en,
    input  logic [15:0]             phase,
    output logic signed [COS_W-1:0] cos_val
);
    logic [14:0] x;
    logic [29:0] xx;
    logic [26:0] y_reg [0:3];
    logic [26:0] y_next;
    logic        neg_reg [0:4];
    logic [34:0] v_reg [0:3];
    logic [61:0] prod [0:3];
    logic [34:0] v_next [0:3];
    logic [28:0] c;
    logic [29:0] c_rnd;
    logic [15:0] mag;
    logic signed [COS_W-1:0] cos_reg;
    logic signed [COS_W-1:0] cos_next;

    // fold by quadrant and square
    always_comb
    begin
        x = phase[14] ? 15'(15'd16384 - {1'b0, phase[13:0]}) : {1'b0, phase[13:0]};
        xx = 30'(x) * 30'(x);
        y_next = 27'(xx >> 2);
    end

    // Horner steps
    always_comb
    begin
        prod[0] = 62'(y_reg[0]) * 62'(COEF_A4);
        v_next[0] = COEF_A3 - 35'(prod[0] >> 30);
        prod[1] = 62'(y_reg[1]) * 62'(v_reg[0]);
        v_next[1] = COEF_A2 - 35'(prod[1] >> 30);
        prod[2] = 62'(y_reg[2]) * 62'(v_reg[1]);
        v_next[2] = COEF_A1 - 35'(prod[2] >> 30);
        prod[3] = 62'(y_reg[3]) * 62'(v_reg[2]);
        v_next[3] = 35'(prod[3] >> 30);
    end

    // clamp, round to Q15, apply sign
    always_comb
    begin
        c = (v_reg[3] >= 35'(ONE_Q28)) ? '0 : 29'(35'(ONE_Q28) - v_reg[3]);
        c_rnd = 30'(c) + 30'd4096;
        mag = 16'(c_rnd >> 13);
        cos_next = neg_reg[4] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            y_reg[0] <= y_next;
            neg_reg[0] <= phase[15] ^ phase[14];
            for (int i = 1; i < 4; i++)
            begin
                y_reg[i] <= y_reg[i-1];
            end
            for (int i = 1; i < 5; i++)
            begin
                neg_reg[i] <= neg_reg[i-1];
            end
            for (int i = 0; i < 4; i++)
            begin
                v_reg[i] <= v_next[i];
            end
            cos_reg <= cos_next;
        end
    end

    assign cos_val = cos_reg;
endmodule

@@ hw/rtl/thht_cell.sv @@
// thht_cell: one constituent of the chain; adds amp*cos at both time points
// to the running sums and hands time and sums on. Depends on thht_pkg, thht_cos.
module thht_cell import thht_pkg::*;
#(
    parameter int PHASE_BITS = 32,
    parameter int K = 0
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [PHASE_BITS-1:0]   in_t0,
    input  logic [PHASE_BITS-1:0]   in_t1,
    input  sum_pair_t               in_sum,
    input  logic signed [AMP_W-1:0] amp,
    output logic                    out_valid,
    output logic [PHASE_BITS-1:0]   out_t0,
    output logic [PHASE_BITS-1:0]   out_t1,
    output sum_pair_t               out_sum
);
    localparam int DLY = 8;
    localparam logic [63:0] INC64 = phase_rate(SPEED_E8[K], PHASE_BITS);
    localparam logic [PHASE_BITS-1:0] INC = INC64[PHASE_BITS-1:0];

    logic [PHASE_BITS-1:0] ph0_next, ph1_next;
    logic [15:0]           p0_reg, p1_reg;
    logic signed [COS_W-1:0] cos0, cos1;
    logic signed [TERM_W-1:0] term0_reg, term1_reg;
    logic [PHASE_BITS-1:0] t0_reg [0:DLY-1];
    logic [PHASE_BITS-1:0] t1_reg [0:DLY-1];
    sum_pair_t             s_reg [0:DLY-1];
    logic [DLY:0]          v_reg;
    sum_pair_t             sum_reg;
    logic [PHASE_BITS-1:0] ot0_reg, ot1_reg;

    assign ph0_next = PHASE_BITS'(INC * in_t0);
    assign ph1_next = PHASE_BITS'(INC * in_t1);

    thht_cos u_cos0 (.clk(clk), .en(en), .phase(p0_reg), .cos_val(cos0));
    thht_cos u_cos1 (.clk(clk), .en(en), .phase(p1_reg), .cos_val(cos1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[DLY-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg <= ph0_next[PHASE_BITS-1 -: 16];
            p1_reg <= ph1_next[PHASE_BITS-1 -: 16];
            term0_reg <= TERM_W'(amp * cos0);
            term1_reg <= TERM_W'(amp * cos1);
            t0_reg[0] <= in_t0;
            t1_reg[0] <= in_t1;
            s_reg[0] <= in_sum;
            for (int i = 1; i < DLY; i++)
            begin
                t0_reg[i] <= t0_reg[i-1];
                t1_reg[i] <= t1_reg[i-1];
                s_reg[i] <= s_reg[i-1];
            end
            ot0_reg <= t0_reg[DLY-1];
            ot1_reg <= t1_reg[DLY-1];
            sum_reg.s0 <= s_reg[DLY-1].s0 + SUM_W'(term0_reg);
            sum_reg.s1 <= s_reg[DLY-1].s1 + SUM_W'(term1_reg);
        end
    end

    assign out_valid = v_reg[DLY];
    assign out_t0 = ot0_reg;
    assign out_t1 = ot1_reg;
    assign out_sum = sum_reg;
endmodule

@@ tb/tb_tide_harmonic_height_trend_core.sv @@
// tb_tide_harmonic_height_trend_core: self-checking bench for the five-constituent
// tide height core; predicts every result in-bench and compares beat by beat.
// Depends on thht_pkg, thht_if and tide_harmonic_height_trend_core.
module tb_tide_harmonic_height_trend_core;
    import thht_pkg::*;

    localparam int PHASE_BITS = 32;
    localparam int TREND_LEAD = 300;
    localparam int PIPE_LAT   = 46;
    // indexes past the datum register; writes there must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    typedef struct {
        logic signed [LEVEL_W-1:0] level;
        logic                      rising;
    } tide_result_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [AMP_W-1:0] cfg_data;

    thht_time_if  req ();
    thht_level_if rsp ();

    tide_harmonic_height_trend_core #(
        .PHASE_BITS(PHASE_BITS),
        .TREND_LEAD(TREND_LEAD)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .req(req),
        .rsp(rsp)
    );

    // bench copy of the amplitude and datum registers
    logic signed [AMP_W-1:0] amp_shadow [NCONST];
    logic signed [AMP_W-1:0] datum_shadow;
    logic [63:0] const_rate [NCONST];

    tide_result_t pending_levels [$];
    int mismatches;
    int levels_checked;
    int beats_sent;
    int cfg_writes;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Turn rate per second of a constituent: speed (1e-8 deg/h) scaled to a
    // PHASE_BITS turn fraction, rounded half up.
    function automatic logic [63:0] turn_rate(input logic [63:0] speed);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = speed;
        quo = '0;
        for (int i = 0; i < PHASE_BITS; i++)
        begin
            rem = rem << 1;
            quo = quo << 1;
            if (rem >= RATE_DIV)
            begin
                rem = rem - RATE_DIV;
                quo[0] = 1'b1;
            end
        end
        rem = rem << 1;
        if (rem >= RATE_DIV)
            quo = quo + 64'd1;
        return quo;
    endfunction

    // Polynomial cosine of a 16-bit turn fraction, signed Q15.
    function automatic logic signed [17:0] cosine_q15(input logic [15:0] p);
        logic [63:0] x;
        logic [63:0] y;
        logic [63:0] v;
        logic [63:0] c;
        logic [63:0] mag;
        logic [63:0] one;
        one = 64'd1 << 28;
        x = (p[14]) ? 64'd16384 - {50'd0, p[13:0]} : {50'd0, p[13:0]};
        y = (x * x) >> 2;
        v = {29'd0, COEF_A4};
        v = {29'd0, COEF_A3} - ((y * v) >> 30);
        v = {29'd0, COEF_A2} - ((y * v) >> 30);
        v = {29'd0, COEF_A1} - ((y * v) >> 30);
        v = (y * v) >> 30;
        c = (v >= one) ? 64'd0 : one - v;
        mag = (c + 64'd4096) >> 13;
        return (p[15] ^ p[14]) ? -$signed(mag[17:0]) : $signed(mag[17:0]);
    endfunction

    function automatic longint height_at(input logic [63:0] t);
        logic [63:0] ph;
        longint acc;
        longint h;
        acc = 0;
        for (int k = 0; k < NCONST; k++)
        begin
            ph = const_rate[k] * t;
            acc += longint'(amp_shadow[k]) * longint'(cosine_q15(ph[PHASE_BITS-1 -: 16]));
        end
        h = (acc + 16384) >>> 15;
        h += longint'(datum_shadow);
        if (h > 262143)
            h = 262143;
        if (h < -262144)
            h = -262144;
        return h;
    endfunction

    function automatic tide_result_t predict_tide(input logic signed [TIME_W-1:0] ts);
        tide_result_t r;
        logic [63:0] t;
        longint h0;
        longint h1;
        t = {{(64-TIME_W){ts[TIME_W-1]}}, ts};
        h0 = height_at(t);
        h1 = height_at(t + TREND_LEAD);
        r.level = h0[LEVEL_W-1:0];
        r.rising = (h1 > h0);
        return r;
    endfunction

    // Drive one timestamp beat; leave valid high so the next beat can follow
    // back to back. Queue the expectation once the beat is taken.
    task automatic send_time(input logic signed [TIME_W-1:0] ts);
        logic rdy;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid <= 1'b1;
        req.time_seconds <= ts;
        do
        begin
            @(negedge clk);
            rdy = req.ready;
            @(posedge clk);
        end
        while (!rdy);
        pending_levels = {pending_levels, predict_tide(ts)};
        beats_sent++;
    endtask

    task automatic drop_valid();
        req.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Wait for the pipe to drain, then let the latency pass before writes.
    task automatic drain_pipe();
        drop_valid();
        wait (pending_levels.size() == 0);
        repeat (PIPE_LAT + 4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [AMP_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx < NCONST)
            amp_shadow[idx] = val;
        else if (idx == REG_DATUM)
            datum_shadow = val;
        cfg_writes++;
    endtask

    task automatic load_all(input logic [AMP_W-1:0] m2, input logic [AMP_W-1:0] s2,
                            input logic [AMP_W-1:0] n2, input logic [AMP_W-1:0] k2,
                            input logic [AMP_W-1:0] m4, input logic [AMP_W-1:0] dat);
        drain_pipe();
        write_reg(REG_AMP_M2, m2);
        write_reg(REG_AMP_S2, s2);
        write_reg(REG_AMP_N2, n2);
        write_reg(REG_AMP_K2, k2);
        write_reg(REG_AMP_M4, m4);
        write_reg(REG_DATUM, dat);
    endtask

    function automatic logic signed [TIME_W-1:0] rand_time();
        logic [63:0] w;
        w = {$urandom(), $urandom()};
        case ($urandom_range(3))
            0: return w[TIME_W-1:0];
            1: return $signed(w[20:0]) ;   // near the epoch, either sign
            2: return {{(TIME_W-32){w[63]}}, w[31:0]};
            default: return w[TIME_W-1:0] ^ {1'b1, {(TIME_W-1){1'b0}}};
        endcase
    endfunction

    // Receiver: random stalls, plus a long hold-off when one is requested.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp.ready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            rsp.ready <= 1'b0;
        end
        else
            rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Compare every result beat against the oldest expectation.
    always @(posedge clk)
    begin
        tide_result_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            if (pending_levels.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: level %0d rising %0b",
                             rsp.tide_level, rsp.rising);
            end
            else
            begin
                want = pending_levels.pop_front();
                levels_checked++;
                if (rsp.tide_level !== want.level || rsp.rising !== want.rising)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: level exp %0d got %0d, rising exp %0b got %0b",
                                 want.level, rsp.tide_level, want.rising, rsp.rising);
                end
            end
        end
    end

    // Epoch, extremes of the time field and the trend step at defaults.
    task automatic test_directed_times();
        logic signed [TIME_W-1:0] t_max;
        logic signed [TIME_W-1:0] t_min;
        t_max = {1'b0, {(TIME_W-1){1'b1}}};
        t_min = {1'b1, {(TIME_W-1){1'b0}}};
        send_time('0);
        send_time(1);
        send_time(-1);
        send_time(TREND_LEAD);
        send_time(-TREND_LEAD);
        send_time(t_max);
        send_time(t_min);
        send_time(t_max - TREND_LEAD);
        send_time(t_max - TREND_LEAD + 1);
        send_time(43200);
        send_time(22357);   // around a quarter M2 period, cosine near zero
        send_time(44714);
        send_time(86400);
        send_time(-86400);
        send_time({TIME_W{1'b1}} ^ 35'h2AAAAAAAA);
        send_time(35'h2AAAAAAAA);
        drop_valid();
    endtask

    // Amplitude and datum extremes, plus writes to unused indexes.
    task automatic test_config_extremes();
        load_all(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_time(0);
        send_time(21600);
        send_time(-1);
        load_all(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_time(0);
        send_time(21600);
        send_time(12345678);
        load_all(16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001, 16'h8000);
        write_reg(REG_SPARE_6, 16'h1234);
        write_reg(REG_SPARE_7, 16'hFFFF);
        send_time(0);
        send_time(7);
        send_time(-300000);
        drop_valid();
    endtask

    // Random timestamps, with random register settings between phases.
    task automatic test_random_sweep(input int count, input int s_idle, input int r_idle);
        drain_pipe();
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        load_all(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
                 16'($urandom()), 16'($urandom()));
        for (int i = 0; i < count; i++)
        begin
            if (i == count / 2)
                load_all(16'($urandom()), 16'($urandom()), 16'($urandom()),
                         16'($urandom()), 16'($urandom()), 16'($urandom()));
            send_time(rand_time());
        end
        drop_valid();
    endtask

    // Hold the receiver off while timestamps keep coming: the pipe fills and
    // must stall its input without losing a beat.
    task automatic test_backpressure();
        drain_pipe();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left = 200;
        for (int i = 0; i < 120; i++)
            send_time(rand_time());
        drop_valid();
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req.valid = 1'b0;
        req.time_seconds = '0;
        mismatches = 0;
        levels_checked = 0;
        beats_sent = 0;
        cfg_writes = 0;
        hold_left = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        amp_shadow[0] = 16'sd4915;
        amp_shadow[1] = 16'sd1638;
        amp_shadow[2] = 16'sd819;
        amp_shadow[3] = 16'sd410;
        amp_shadow[4] = 16'sd410;
        datum_shadow = 16'sd4096;
        for (int k = 0; k < NCONST; k++)
            const_rate[k] = turn_rate(SPEED_E8[k]);
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_times();
        test_config_extremes();
        test_random_sweep(150, 11, 64);
        test_random_sweep(150, 64, 11);
        test_random_sweep(150, 0, 0);
        test_backpressure();

        wait (pending_levels.size() == 0);
        repeat (PIPE_LAT + 10) @(posedge clk);
        $display("covered %0d timestamps, %0d results checked, %0d register writes",
                 beats_sent, levels_checked, cfg_writes);
        $display("mismatches: %0d (directed, extremes, random sweeps, long stall)",
                 mismatches);
        if (mismatches == 0 && pending_levels.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("timeout");
        $display("== FAIL ==");
        $finish;
    end

endmodule
